/* hdl/asp_pkg.sv */
// Shared types, constants and elaboration-time functions of the angular sector point filter.
// Holds the CORDIC arctangent table builder and the register reset values.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_RANGES  = 4;
  localparam int DEF_COORD_WIDTH = 16;

  // Configuration register file.
  localparam int REG_COUNT  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int ANGLE_W    = 15;

  // Bearing arithmetic.
  localparam int CORDIC_ITERS = 59;
  localparam int AFRAC        = 58;
  localparam int NORM_MSB     = 59;
  localparam int SH_W         = 6;
  localparam int MAG_W        = 60;
  localparam int Q_SHIFT      = AFRAC - 12;

  // Register latency from an accepted command to its result strobe:
  // three normalization stages, one per CORDIC iteration, two finishing
  // stages and the sector compare with the output register.
  localparam int PIPE_LAT = 3 + CORDIC_ITERS + 2 + 1;

  // Control fields that travel alongside every item in the pipeline.
  typedef struct packed {
    logic                      valid;
    logic                      xneg;
    logic                      yneg;
    logic                      spec;
    logic signed [ANGLE_W-1:0] spec_angle;
  } ctl_t;

  // Reset values of the sector bounds, in register index order.
  localparam logic signed [ANGLE_W-1:0] REG_RESET [REG_COUNT] = '{
    -15'sd6434, 15'sd6434, 15'sd12868, -15'sd12868,
    15'sd12868, -15'sd12868, 15'sd12868, -15'sd12868
  };

  // Restoring division, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i scaled by 2^62, by its alternating series.
  function automatic logic [63:0] atan_pow2_62(input int unsigned i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned k;
    p   = 64'd1 << (62 - i);
    sum = '0;
    k   = 0;
    while (p != 64'd0) begin
      term = udiv64(p, 64'(2 * k + 1));
      if (k[0] == 1'b0) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
      k++;
      p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
    end
    return sum;
  endfunction

  // Arctangent of 1/3 scaled by 2^62.
  function automatic logic [63:0] atan_third_62();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned k;
    p   = udiv64(64'd1 << 62, 64'd3);
    sum = '0;
    k   = 0;
    while (p != 64'd0) begin
      term = udiv64(p, 64'(2 * k + 1));
      if (k[0] == 1'b0) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
      k++;
      p = udiv64(p, 64'd9);
    end
    return sum;
  endfunction

  // CORDIC angle of iteration i with AFRAC fractional bits, rounded.
  // The first entry is atan(1) built from atan(1/2) + atan(1/3).
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] raw;
    if (i == 0) begin
      raw = atan_pow2_62(1) + atan_third_62();
    end else begin
      raw = atan_pow2_62(i);
    end
    return (raw + 64'd8) >> 4;
  endfunction

  localparam logic [63:0] ATAN0      = atan_entry(0);
  localparam logic [63:0] HALF_PI_Z  = ATAN0 << 1;
  localparam logic [63:0] PI_Z       = ATAN0 << 2;
  localparam logic [63:0] ROUND_BIAS = 64'd1 << (Q_SHIFT - 1);

  // Rounded Q3.12 bearings of the axis cases.
  localparam logic signed [ANGLE_W-1:0] PI_Q      = ANGLE_W'((PI_Z + ROUND_BIAS) >> Q_SHIFT);
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q =
    ANGLE_W'((HALF_PI_Z + ROUND_BIAS) >> Q_SHIFT);

endpackage

`default_nettype wire

/* hdl/asp_prep.sv */
// Front end of the bearing pipeline: magnitudes, axis cases and normalization.
// Three register stages; depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asp_prep #(
  parameter int COORD_WIDTH = asp_pkg::DEF_COORD_WIDTH,
  parameter int TAG_W       = 3 * asp_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic        [TAG_W-1:0]       tag_in,
  output asp_pkg::ctl_t                 ctl_out,
  output logic        [63:0]            cx_out,
  output logic        [63:0]            cy_out,
  output logic        [TAG_W-1:0]       tag_out
);
  import asp_pkg::*;

  localparam int HALF  = COORD_WIDTH / 2;
  localparam int POS_W = $clog2(COORD_WIDTH);

  // Stage 1: absolute values and the axis cases.
  ctl_t                   ctl1_next;
  logic [COORD_WIDTH-1:0] ax1_next;
  logic [COORD_WIDTH-1:0] ay1_next;
  ctl_t                   ctl1;
  logic [COORD_WIDTH-1:0] ax1;
  logic [COORD_WIDTH-1:0] ay1;
  logic [TAG_W-1:0]       tag1;

  always_comb begin
    ax1_next             = point_x[COORD_WIDTH-1] ? COORD_WIDTH'(-point_x) : point_x;
    ay1_next             = point_y[COORD_WIDTH-1] ? COORD_WIDTH'(-point_y) : point_y;
    ctl1_next.valid      = in_valid;
    ctl1_next.xneg       = point_x[COORD_WIDTH-1];
    ctl1_next.yneg       = point_y[COORD_WIDTH-1];
    ctl1_next.spec       = 1'b0;
    ctl1_next.spec_angle = '0;
    if (point_y == '0) begin
      ctl1_next.spec       = 1'b1;
      ctl1_next.spec_angle = point_x[COORD_WIDTH-1] ? PI_Q : '0;
    end else if (point_x == '0) begin
      ctl1_next.spec       = 1'b1;
      ctl1_next.spec_angle = point_y[COORD_WIDTH-1] ? -HALF_PI_Q : HALF_PI_Q;
    end
  end

  // Stage 2: leading one of the larger magnitude, searched per half word.
  logic [COORD_WIDTH-1:0] mx;
  logic                   hi_any_next;
  logic [POS_W-1:0]       hi_pos_next;
  logic [POS_W-1:0]       lo_pos_next;
  ctl_t                   ctl2;
  logic [COORD_WIDTH-1:0] ax2;
  logic [COORD_WIDTH-1:0] ay2;
  logic                   hi_any;
  logic [POS_W-1:0]       hi_pos;
  logic [POS_W-1:0]       lo_pos;
  logic [TAG_W-1:0]       tag2;

  always_comb begin
    mx          = (ax1 > ay1) ? ax1 : ay1;
    hi_any_next = |mx[COORD_WIDTH-1:HALF];
    hi_pos_next = '0;
    lo_pos_next = '0;
    for (int b = 0; b < HALF; b++) begin
      if (mx[b]) begin
        lo_pos_next = POS_W'(b);
      end
    end
    for (int b = HALF; b < COORD_WIDTH; b++) begin
      if (mx[b]) begin
        hi_pos_next = POS_W'(b);
      end
    end
  end

  // Stage 3: shift both magnitudes so the larger has its top bit at NORM_MSB.
  logic [POS_W-1:0] msb_pos;
  logic [SH_W-1:0]  shamt;

  assign msb_pos = hi_any ? hi_pos : lo_pos;
  assign shamt   = SH_W'(NORM_MSB - int'(msb_pos));

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= ctl1_next;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ax1     <= ax1_next;
    ay1     <= ay1_next;
    tag1    <= tag_in;
    ax2     <= ax1;
    ay2     <= ay1;
    hi_any  <= hi_any_next;
    hi_pos  <= hi_pos_next;
    lo_pos  <= lo_pos_next;
    tag2    <= tag1;
    cx_out  <= 64'(ax2) << shamt;
    cy_out  <= 64'(ay2) << shamt;
    tag_out <= tag2;
  end

endmodule

`default_nettype wire

/* hdl/asp_cordic_stage.sv */
// One vectoring CORDIC iteration with its own register stage.
// Instanced once per iteration by the top level; depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asp_cordic_stage #(
  parameter int STAGE = 0,
  parameter int TAG_W = 3 * asp_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  asp_pkg::ctl_t         ctl_in,
  input  logic [63:0]           cx_in,
  input  logic [63:0]           cy_in,
  input  logic [63:0]           z_in,
  input  logic [TAG_W-1:0]      tag_in,
  output asp_pkg::ctl_t         ctl_out,
  output logic [63:0]           cx_out,
  output logic [63:0]           cy_out,
  output logic [63:0]           z_out,
  output logic [TAG_W-1:0]      tag_out
);
  import asp_pkg::*;

  localparam logic [63:0] ANGLE = atan_entry(STAGE);

  // Shifted cross terms: y shifts arithmetically, x logically.
  logic [63:0] dx;
  logic [63:0] dy;

  assign dx = 64'($signed(cy_in) >>> STAGE);
  assign dy = cx_in >> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Rotate toward the x axis; the sign of y picks the direction.
  always_ff @(posedge clk) begin
    if (!cy_in[63]) begin
      cx_out <= cx_in + dx;
      cy_out <= cy_in - dy;
      z_out  <= z_in + ANGLE;
    end else begin
      cx_out <= cx_in - dx;
      cy_out <= cy_in + dy;
      z_out  <= z_in - ANGLE;
    end
    tag_out <= tag_in;
  end

endmodule

`default_nettype wire

/* hdl/asp_post.sv */
// Back end of the bearing pipeline: clamp, quadrant mirror, rounding and sign.
// Two register stages; depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asp_post #(
  parameter int TAG_W = 3 * asp_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  asp_pkg::ctl_t                      ctl_in,
  input  logic [63:0]                        z_in,
  input  logic [TAG_W-1:0]                   tag_in,
  output logic                               valid_out,
  output logic signed [asp_pkg::ANGLE_W-1:0] angle_out,
  output logic [TAG_W-1:0]                   tag_out
);
  import asp_pkg::*;

  // Stage 1: clamp to [0, pi/2] and, when x is negative, mirror into the left half plane.
  logic [63:0]      zc;
  logic [MAG_W-1:0] mag_next;
  ctl_t             ctl1;
  logic [MAG_W-1:0] mag;
  logic [TAG_W-1:0] tag1;

  always_comb begin
    zc = z_in[63] ? 64'd0 : z_in;
    if (zc > HALF_PI_Z) begin
      zc = HALF_PI_Z;
    end
    mag_next = ctl_in.xneg ? MAG_W'(PI_Z - zc) : MAG_W'(zc);
  end

  // Stage 2: round half up to Q3.12, apply the sign of y, or take an axis case.
  logic [MAG_W-1:0]          rsum;
  logic signed [ANGLE_W-1:0] q;
  logic signed [ANGLE_W-1:0] angle_next;

  always_comb begin
    rsum       = mag + MAG_W'(ROUND_BIAS);
    q          = {1'b0, rsum[MAG_W-1:Q_SHIFT]};
    angle_next = ctl1.yneg ? -q : q;
    if (ctl1.spec) begin
      angle_next = ctl1.spec_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1      <= '0;
      valid_out <= 1'b0;
    end else begin
      ctl1      <= ctl_in;
      valid_out <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    tag1      <= tag_in;
    angle_out <= angle_next;
    tag_out   <= tag1;
  end

endmodule

`default_nettype wire

/* hdl/asp_sector.sv */
// Sector bound registers, the range test and the output register.
// Takes configuration writes on its own channel; depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asp_sector #(
  parameter int NUM_RANGES  = asp_pkg::DEF_NUM_RANGES,
  parameter int COORD_WIDTH = asp_pkg::DEF_COORD_WIDTH,
  parameter int TAG_W       = 3 * asp_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [asp_pkg::ANGLE_W-1:0]   angle,
  input  logic        [TAG_W-1:0]              tag_in,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [asp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic signed [asp_pkg::ANGLE_W-1:0]   cfg_data,
  output logic                                 done,
  output logic                                 keep,
  output logic signed [COORD_WIDTH-1:0]        out_x,
  output logic signed [COORD_WIDTH-1:0]        out_y,
  output logic signed [COORD_WIDTH-1:0]        out_z,
  output logic                                 last_out
);
  import asp_pkg::*;

  localparam int NREG = 2 * NUM_RANGES;

  // Bound registers: even entries are low bounds, odd entries high bounds.
  logic signed [ANGLE_W-1:0] bounds [NREG];

  assign cfg_ready = 1'b1;

  // Register writes; an index past the used registers is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        bounds[i] <= REG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NREG; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          bounds[i] <= cfg_data;
        end
      end
    end
  end

  // A sector holds the bearing when it is enabled and brackets it.
  logic keep_next;

  always_comb begin
    keep_next = 1'b0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (bounds[2*r] <= bounds[2*r+1] && bounds[2*r] <= angle && angle <= bounds[2*r+1]) begin
        keep_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Output payload: the point passed through with its flags.
  always_ff @(posedge clk) begin
    keep     <= keep_next;
    out_x    <= tag_in[TAG_W-1 -: COORD_WIDTH];
    out_y    <= tag_in[TAG_W-1-COORD_WIDTH -: COORD_WIDTH];
    out_z    <= tag_in[TAG_W-1-2*COORD_WIDTH -: COORD_WIDTH];
    last_out <= tag_in[0];
  end

endmodule

`default_nettype wire

/* hdl/angular_sector_point_filter.sv */
// Top level of the angular sector point filter: the full bearing pipeline.
// Instances asp_prep, asp_cordic_stage, asp_post and asp_sector; depends on asp_pkg.
//
// Use: present one point on point_x, point_y, point_z and last_in with start
// high; the command transaction is taken at a rising edge where start is high
// and busy is low. busy is low whenever reset is released, so a new point can
// be taken on every clock: throughput is one point per cycle.
// Each point gives one result, carried through three normalization stages,
// one stage per CORDIC iteration (59), two finishing stages and the sector
// compare with the output register. The result is shown for one cycle with
// done high and must be captured then; the receiver cannot stall the block,
// and no back pressure exists.
// Sector bounds are written over the cfg channel (cfg_ready is always high),
// register i at index i; writes are meant to happen while no points are in
// flight. Synchronous reset empties the pipeline, restores the default
// bounds (sector 0 is -pi/2..pi/2, the others disabled) and holds busy high.
`timescale 1ns / 1ps
`default_nettype none

module angular_sector_point_filter #(
  parameter int NUM_RANGES  = asp_pkg::DEF_NUM_RANGES,
  parameter int COORD_WIDTH = asp_pkg::DEF_COORD_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        point_x,
  input  logic signed [COORD_WIDTH-1:0]        point_y,
  input  logic signed [COORD_WIDTH-1:0]        point_z,
  input  logic                                 last_in,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [asp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic signed [asp_pkg::ANGLE_W-1:0]   cfg_data,
  output logic                                 done,
  output logic                                 keep,
  output logic signed [COORD_WIDTH-1:0]        out_x,
  output logic signed [COORD_WIDTH-1:0]        out_y,
  output logic signed [COORD_WIDTH-1:0]        out_z,
  output logic                                 last_out
);
  import asp_pkg::*;

  localparam int TAG_W = 3 * COORD_WIDTH + 1;

  logic in_valid;

  // The pipeline never stalls; it refuses commands only during reset.
  assign busy     = rst;
  assign in_valid = start && !busy;

  // Links between pipeline stages.
  ctl_t              ctl_w [CORDIC_ITERS+1];
  logic [63:0]       cx_w  [CORDIC_ITERS+1];
  logic [63:0]       cy_w  [CORDIC_ITERS+1];
  logic [63:0]       z_w   [CORDIC_ITERS+1];
  logic [TAG_W-1:0]  tag_w [CORDIC_ITERS+1];
  logic [TAG_W-1:0]  tag_in;

  assign tag_in = {point_x, point_y, point_z, last_in};
  assign z_w[0] = '0;

  asp_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .TAG_W       (TAG_W)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .point_x  (point_x),
    .point_y  (point_y),
    .tag_in   (tag_in),
    .ctl_out  (ctl_w[0]),
    .cx_out   (cx_w[0]),
    .cy_out   (cy_w[0]),
    .tag_out  (tag_w[0])
  );

  // One register stage per CORDIC iteration.
  for (genvar s = 0; s < CORDIC_ITERS; s++) begin : g_cordic
    asp_cordic_stage #(
      .STAGE (s),
      .TAG_W (TAG_W)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_w[s]),
      .cx_in   (cx_w[s]),
      .cy_in   (cy_w[s]),
      .z_in    (z_w[s]),
      .tag_in  (tag_w[s]),
      .ctl_out (ctl_w[s+1]),
      .cx_out  (cx_w[s+1]),
      .cy_out  (cy_w[s+1]),
      .z_out   (z_w[s+1]),
      .tag_out (tag_w[s+1])
    );
  end

  logic                      post_valid;
  logic signed [ANGLE_W-1:0] post_angle;
  logic [TAG_W-1:0]          post_tag;

  asp_post #(
    .TAG_W (TAG_W)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_w[CORDIC_ITERS]),
    .z_in      (z_w[CORDIC_ITERS]),
    .tag_in    (tag_w[CORDIC_ITERS]),
    .valid_out (post_valid),
    .angle_out (post_angle),
    .tag_out   (post_tag)
  );

  asp_sector #(
    .NUM_RANGES  (NUM_RANGES),
    .COORD_WIDTH (COORD_WIDTH),
    .TAG_W       (TAG_W)
  ) u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (post_valid),
    .angle     (post_angle),
    .tag_in    (post_tag),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .keep      (keep),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .last_out  (last_out)
  );

  // Every result strobe traces back to a command that was taken.
  a_done_has_command: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching command");

  // Every command taken gives its result strobe.
  a_command_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("command lost in the pipeline");

  // The point data stays aligned with its valid bit through all stages.
  a_payload_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_x == $past(point_x, PIPE_LAT) && out_z == $past(point_z, PIPE_LAT)
              && last_out == $past(last_in, PIPE_LAT)))
    else $error("result payload out of step with its strobe");

endmodule

`default_nettype wire
